FILE: sv/ssbpam_pkg.sv
// Shared types, constants and codes for the SSB phase/amplitude modulator.
// Depends on nothing; every other file of the block imports it.
package ssbpam_pkg;

  // Angle unit: one full turn of the carrier phase is UNIT_ANGLE steps.
  localparam int UNIT_ANGLE  = 600;
  localparam int SAMPLE_RATE = 4800;
  localparam int FREQ_SCALE  = SAMPLE_RATE / UNIT_ANGLE;
  localparam int QUARTER     = UNIT_ANGLE / 4;
  localparam int HALF_TURN   = UNIT_ANGLE / 2;
  localparam int OCT_SLOPE   = UNIT_ANGLE / 22;
  localparam int OCT_BASE    = UNIT_ANGLE / 8 + OCT_SLOPE;

  // Voice trigger hang counter loads.
  localparam logic [7:0] HANG_FIRST = 8'd255;
  localparam logic [7:0] HANG_NEXT  = 8'd254;

  // Amplitude drive.
  localparam logic [3:0] DRIVE_FULL = 4'd8;
  localparam logic [7:0] LEVEL_MAX  = 8'd255;

  // Bandwidth mode codes with their own phase-step limit.
  localparam logic [1:0] BW_WIDE   = 2'd0;
  localparam logic [1:0] BW_NARROW = 2'd3;

  // Division by three: multiply by ceil(2^17 / 3), exact below 2^17.
  localparam int          RECIP3_SHIFT = 17;
  localparam logic [16:0] RECIP3       = 17'd43691;

  // Queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Width of the arctangent divider remainder.
  localparam int DIV_W = 24;

  typedef enum logic [1:0] {
    CFG_DRIVE_SHIFT     = 2'd0,
    CFG_VOICE_THRESHOLD = 2'd1,
    CFG_BANDWIDTH_MODE  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    F_SUM,
    F_MUL,
    F_FIN
  } front_state_t;

  typedef struct packed {
    logic [3:0] drive_shift;
    logic [7:0] voice_threshold;
    logic [1:0] bandwidth_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] i;
    logic signed [15:0] q;
  } iq_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: sv/ssbpam_front.sv
// Front part: input holding register, low-pass/notch and DC-removal filters,
// 16-tap delay line and integer Hilbert transformer. Imports ssbpam_pkg.
module ssbpam_front import ssbpam_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [12:0] in_mic_sample,
  output logic               push,
  output iq_t                push_data,
  input  fifo_stat_t         fifo_stat
);

  localparam int HIL_SHIFT = 6;

  front_state_t       state_r, state_nxt;
  logic               x_v_r;
  logic signed [12:0] x_r;
  logic signed [15:0] ac_r;
  logic signed [17:0] s1_r, s2_r;
  logic        [33:0] p1_r, p2_r;
  logic               n1_r, n2_r;
  logic signed [15:0] lpm_r, dc_r;
  logic signed [15:0] dly_r [16];
  logic               hil_v_r, hil_v_nxt;

  logic               take, fin_go;
  logic signed [15:0] ac_c;
  logic signed [17:0] s1_c, s2_c;
  logic        [17:0] m1_c, m2_c;
  logic        [16:0] q1_c, q2_c, d1_c, d2_c;
  logic signed [15:0] lpm_nxt, dc_nxt, tap_nxt;
  logic signed [16:0] e0, e2, e4, e6;
  logic signed [23:0] hsum, hdiv, qsum;

  assign take     = (state_r == F_SUM) && x_v_r;
  assign in_ready = !x_v_r || take;

  // Filter arithmetic, one piece per state.
  assign ac_c = {{2{x_r[12]}}, x_r, 1'b0} + lpm_r;
  assign s1_c = {{5{x_r[12]}}, x_r} - {lpm_r[15], lpm_r, 1'b0};
  assign s2_c = {{2{ac_c[15]}}, ac_c} + {dc_r[15], dc_r, 1'b0};

  assign m1_c = s1_r[17] ? -s1_r : s1_r;
  assign m2_c = s2_r[17] ? -s2_r : s2_r;

  assign q1_c    = p1_r[33:RECIP3_SHIFT];
  assign q2_c    = p2_r[33:RECIP3_SHIFT];
  assign d1_c    = n1_r ? -q1_c : q1_c;
  assign d2_c    = n2_r ? -q2_c : q2_c;
  assign lpm_nxt = d1_c[15:0];
  assign dc_nxt  = d2_c[15:0];
  assign tap_nxt = ac_r - dc_nxt;

  // Hilbert transformer on the delay line, quotient truncated toward zero.
  assign e0   = {dly_r[0][15], dly_r[0]} - {dly_r[14][15], dly_r[14]};
  assign e2   = {dly_r[2][15], dly_r[2]} - {dly_r[12][15], dly_r[12]};
  assign e4   = {dly_r[4][15], dly_r[4]} - {dly_r[10][15], dly_r[10]};
  assign e6   = {dly_r[6][15], dly_r[6]} - {dly_r[8][15], dly_r[8]};
  assign hsum = (24'(e0) <<< 1) + (24'(e2) <<< 3) + 24'(e4) * 24'sd21 + (24'(e6) <<< 4);
  assign hdiv = (hsum + (hsum[23] ? 24'sd63 : 24'sd0)) >>> HIL_SHIFT;
  assign qsum = hdiv + 24'(e6);

  assign push        = hil_v_r && !fifo_stat.full;
  assign push_data.i = {dly_r[7][14:0], 1'b0};
  assign push_data.q = qsum[15:0];

  always_comb begin
    state_nxt = state_r;
    fin_go    = 1'b0;
    case (state_r)
      F_SUM: begin
        if (x_v_r) state_nxt = F_MUL;
      end
      F_MUL: begin
        state_nxt = F_FIN;
      end
      F_FIN: begin
        fin_go = !hil_v_r || push;
        if (fin_go) state_nxt = F_SUM;
      end
      default: begin
        state_nxt = F_SUM;
      end
    endcase
    hil_v_nxt = fin_go ? 1'b1 : (push ? 1'b0 : hil_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_SUM;
      x_v_r   <= 1'b0;
      hil_v_r <= 1'b0;
      lpm_r   <= '0;
      dc_r    <= '0;
      for (int k = 0; k < 16; k++) dly_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      hil_v_r <= hil_v_nxt;
      if (in_valid && in_ready) begin
        x_v_r <= 1'b1;
      end else if (take) begin
        x_v_r <= 1'b0;
      end
      if (fin_go) begin
        lpm_r <= lpm_nxt;
        dc_r  <= dc_nxt;
        for (int k = 0; k < 15; k++) dly_r[k] <= dly_r[k + 1];
        dly_r[15] <= tap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) x_r <= in_mic_sample;
    if (take) begin
      ac_r <= ac_c;
      s1_r <= s1_c;
      s2_r <= s2_c;
    end
    if (state_r == F_MUL) begin
      p1_r <= 34'(m1_c[16:0] * RECIP3);
      p2_r <= 34'(m2_c[16:0] * RECIP3);
      n1_r <= s1_r[17];
      n2_r <= s2_r[17];
    end
  end

endmodule

FILE: sv/ssbpam_fifo.sv
// Short queue of I/Q pairs between the front and back parts.
// Imports ssbpam_pkg for the item type and the depth.
module ssbpam_fifo import ssbpam_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  iq_t        push_data,
  input  logic       pop,
  output iq_t        pop_data,
  output fifo_stat_t stat
);

  iq_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;

  assign stat.full  = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

FILE: sv/ssbpam_back.sv
// Back part: magnitude, hang counter and level, pipelined arctangent with a
// divider of at most two bits per stage, phase-step limiter and output
// register. Imports ssbpam_pkg.
module ssbpam_back import ssbpam_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  fifo_stat_t  fifo_stat,
  output logic        pop,
  input  iq_t         pop_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_freq_offset,
  output logic [7:0]  out_amplitude_level,
  output logic        out_transmit_active
);

  typedef struct packed {
    logic [16:0] a;
    logic [16:0] b;
    logic        swapped;
    logic        ineg;
    logic        qneg;
    logic [7:0]  level;
    logic        tx;
  } back_ctx_t;

  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic [16:0] den,
                                              input int unsigned sh);
    logic [DIV_W-1:0] d;
    d = DIV_W'(den) << sh;
    if (rem >= d) return {1'b1, rem - d};
    return {1'b0, rem};
  endfunction

  logic [7:0]         v_r;
  back_ctx_t          ctx_r [8];
  logic [DIV_W-1:0]   rem_r [7];
  logic [6:0]         quo_r [7];
  logic signed [15:0] phase_r, prev_r;
  logic [7:0]         hang_r;
  logic               out_valid_r;
  logic [12:0]        freq_r;
  logic [7:0]         level_r;
  logic               tx_r;

  logic               adv;
  back_ctx_t          ctx0_nxt;
  logic [DIV_W-1:0]   rem_nxt [7];
  logic [6:0]         quo_nxt [7];
  logic [7:0]         hang_nxt;
  logic signed [15:0] phase_nxt, prev_nxt;
  logic [12:0]        freq_nxt;

  // Stage 0 temporaries.
  logic signed [15:0] hi, hq;
  logic [15:0]        ahi, ahq, mag, lvl16;
  logic [30:0]        shifted;
  logic signed [16:0] ie, qe;
  logic [16:0]        ai, aq;
  // Divider temporaries.
  logic [DIV_W:0]     t1, t2, t3, t4, t5, t6, t7, t8, t9, t10, t11, t12;
  logic [6:0]         q1, k, oct;
  logic signed [15:0] r0, r1;
  // Output stage temporaries.
  logic signed [15:0] dp0, dp1, dp2, lim;
  logic [15:0]        f16;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !fifo_stat.empty;

  always_comb begin
    // Magnitude approximation on the halved I and Q.
    hi  = pop_data.i >>> 1;
    hq  = (pop_data.q + (pop_data.q[15] ? 16'sd1 : 16'sd0)) >>> 1;
    ahi = hi[15] ? -hi : hi;
    ahq = hq[15] ? -hq : hq;
    mag = (ahi > ahq) ? ahi + (ahq >> 2) : ahq + (ahi >> 2);

    if (mag > {8'd0, cfg.voice_threshold}) begin
      hang_nxt = (hang_r == '0) ? HANG_FIRST : HANG_NEXT;
    end else if (hang_r != '0) begin
      hang_nxt = hang_r - 1'b1;
    end else begin
      hang_nxt = '0;
    end

    shifted = 31'(mag) << cfg.drive_shift;
    lvl16   = shifted[15:0];
    if (lvl16 > 16'(LEVEL_MAX) || cfg.drive_shift == DRIVE_FULL) begin
      ctx0_nxt.level = LEVEL_MAX;
    end else begin
      ctx0_nxt.level = lvl16[7:0];
    end
    if (hang_nxt == '0) ctx0_nxt.level = '0;
    ctx0_nxt.tx = (hang_nxt != '0);

    // Octant folding for the arctangent.
    ie = 17'(pop_data.i);
    qe = 17'(pop_data.q);
    ai = ie[16] ? -ie : ie;
    aq = qe[16] ? -qe : qe;
    ctx0_nxt.swapped = (aq > ai);
    ctx0_nxt.ineg    = pop_data.i[15];
    ctx0_nxt.qneg    = pop_data.q[15];
    ctx0_nxt.a       = ctx0_nxt.swapped ? ai : aq;
    if (ctx0_nxt.swapped) begin
      ctx0_nxt.b = aq;
    end else begin
      ctx0_nxt.b = (ai == '0) ? 17'd1 : ai;
    end
    rem_nxt[0] = DIV_W'(ctx0_nxt.a) * DIV_W'(OCT_SLOPE);
    quo_nxt[0] = '0;

    // First division: slope term, five quotient bits.
    t1 = div_step(rem_r[0], ctx_r[0].b, 4);
    t2 = div_step(t1[DIV_W-1:0], ctx_r[0].b, 3);
    rem_nxt[1] = t2[DIV_W-1:0];
    quo_nxt[1] = {quo_r[0][4:0], t1[DIV_W], t2[DIV_W]};

    t3 = div_step(rem_r[1], ctx_r[1].b, 2);
    t4 = div_step(t3[DIV_W-1:0], ctx_r[1].b, 1);
    rem_nxt[2] = t4[DIV_W-1:0];
    quo_nxt[2] = {quo_r[1][4:0], t3[DIV_W], t4[DIV_W]};

    t5 = div_step(rem_r[2], ctx_r[2].b, 0);
    q1 = {quo_r[2][5:0], t5[DIV_W]};
    k  = 7'(OCT_BASE) - q1;
    rem_nxt[3] = DIV_W'(k) * DIV_W'(ctx_r[2].a);
    quo_nxt[3] = '0;

    // Second division: octant angle, seven quotient bits.
    t6 = div_step(rem_r[3], ctx_r[3].b, 6);
    t7 = div_step(t6[DIV_W-1:0], ctx_r[3].b, 5);
    rem_nxt[4] = t7[DIV_W-1:0];
    quo_nxt[4] = {quo_r[3][4:0], t6[DIV_W], t7[DIV_W]};

    t8 = div_step(rem_r[4], ctx_r[4].b, 4);
    t9 = div_step(t8[DIV_W-1:0], ctx_r[4].b, 3);
    rem_nxt[5] = t9[DIV_W-1:0];
    quo_nxt[5] = {quo_r[4][4:0], t8[DIV_W], t9[DIV_W]};

    t10 = div_step(rem_r[5], ctx_r[5].b, 2);
    t11 = div_step(t10[DIV_W-1:0], ctx_r[5].b, 1);
    rem_nxt[6] = t11[DIV_W-1:0];
    quo_nxt[6] = {quo_r[5][4:0], t10[DIV_W], t11[DIV_W]};

    t12 = div_step(rem_r[6], ctx_r[6].b, 0);
    oct = {quo_r[6][5:0], t12[DIV_W]};
    r0  = ctx_r[6].swapped ? 16'(QUARTER) - 16'(oct) : 16'(oct);
    r1  = ctx_r[6].ineg ? 16'(HALF_TURN) - r0 : r0;
    phase_nxt = ctx_r[6].qneg ? -r1 : r1;

    // Phase step, wrapped positive and limited.
    dp0 = phase_r - prev_r;
    dp1 = dp0[15] ? dp0 + 16'(UNIT_ANGLE) : dp0;
    case (cfg.bandwidth_mode)
      BW_WIDE:   lim = 16'(UNIT_ANGLE);
      BW_NARROW: lim = 16'(QUARTER);
      default:   lim = 16'(HALF_TURN);
    endcase
    if (dp1 > lim) begin
      prev_nxt = phase_r - (dp1 - lim);
      dp2      = lim;
    end else begin
      prev_nxt = phase_r;
      dp2      = dp1;
    end
    f16      = dp2 * 16'(FREQ_SCALE);
    freq_nxt = f16[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      hang_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[6:0], pop};
      out_valid_r <= v_r[7];
      if (v_r[7]) prev_r <= prev_nxt;
      if (pop) hang_r <= hang_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r[0] <= ctx0_nxt;
      for (int s = 1; s < 8; s++) ctx_r[s] <= ctx_r[s - 1];
      for (int s = 0; s < 7; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
      phase_r <= phase_nxt;
      freq_r  <= freq_nxt;
      level_r <= ctx_r[7].level;
      tx_r    <= ctx_r[7].tx;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_freq_offset     = freq_r;
  assign out_amplitude_level = level_r;
  assign out_transmit_active = tx_r;

  a_level_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_transmit_active || out_amplitude_level == '0))
    else $error("amplitude present while transmit inactive");

  a_hang_first_load: assert property (@(posedge clk) disable iff (!rst_n)
    (hang_r == HANG_FIRST && $past(hang_r) != HANG_FIRST) |-> $past(hang_r) == '0)
    else $error("hang counter took its first load while already running");

endmodule

FILE: sv/ssb_phase_amplitude_modulator.sv
// Top level of the SSB phase/amplitude modulator: configuration registers and
// the front part, queue and back part. Imports ssbpam_pkg.
//
// The input rate is bounded by the filter recursion in the front part: each
// sample passes the sum, reciprocal-multiply and final-update steps in turn
// (reciprocal multiply for the two divisions by three), while the next sample
// may already wait in the input register.
// Reset is synchronous and active low: filters, delay line, last phase and hang
// counter clear to zero, registers load drive 2, threshold 4, bandwidth mode 0.
module ssb_phase_amplitude_modulator import ssbpam_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [12:0] in_mic_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [12:0]        out_freq_offset,
  output logic [7:0]         out_amplitude_level,
  output logic               out_transmit_active,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  // The front part holds one sample in an input register, so the input side
  // keeps taking transactions while earlier samples move through the filters.
  // Each sample runs through three steps: the sums of the low-pass and DC
  // stages, the reciprocal multiply, and the final update of the filter state
  // and the delay line. The Hilbert transformer then turns the delay line into
  // an I/Q pair that is written into the queue.

  // The back part reads the queue whenever its pipeline can advance. It has
  // nine register stages: magnitude and hang counter first, then two divisions
  // done at most two quotient bits per stage, then the phase step against the
  // previous phase into the output register. The whole pipeline stalls together
  // when the output transaction is not taken, and the queue absorbs the front's
  // output meanwhile.

  cfg_t       cfg_r;
  logic       push, pop;
  iq_t        push_data, pop_data;
  fifo_stat_t fifo_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_shift     <= 4'd2;
      cfg_r.voice_threshold <= 8'd4;
      cfg_r.bandwidth_mode  <= BW_WIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRIVE_SHIFT:     cfg_r.drive_shift     <= cfg_data[3:0];
        CFG_VOICE_THRESHOLD: cfg_r.voice_threshold <= cfg_data;
        CFG_BANDWIDTH_MODE:  cfg_r.bandwidth_mode  <= cfg_data[1:0];
        default: begin
          // Writes to an index beyond the register list are ignored.
        end
      endcase
    end
  end

  ssbpam_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mic_sample (in_mic_sample),
    .push          (push),
    .push_data     (push_data),
    .fifo_stat     (fifo_stat)
  );

  ssbpam_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  ssbpam_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .fifo_stat           (fifo_stat),
    .pop                 (pop),
    .pop_data            (pop_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_freq_offset     (out_freq_offset),
    .out_amplitude_level (out_amplitude_level),
    .out_transmit_active (out_transmit_active)
  );

endmodule

FILE: tb/ssbpam_checker.sv
`timescale 1ns / 100ps
// Result checker for the SSB phase/amplitude modulator: a bit-exact predictor
// and an in-order store of expected results. Depends on ssbpam_pkg only.
module ssbpam_checker import ssbpam_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [12:0] in_mic_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [12:0]        out_freq_offset,
  input  logic [7:0]         out_amplitude_level,
  input  logic               out_transmit_active,
  input  logic               cfg_we,
  input  cfg_index_t         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [12:0] freq_offset;
    logic [7:0]  amplitude_level;
    logic        transmit_active;
  } ssb_result_t;

  // Register copies
  logic [3:0] drive_shift;
  logic [7:0] voice_threshold;
  logic [1:0] bandwidth_mode;

  // Filter, delay line, phase and voice trigger state
  int         lowpass_mem;
  int         dc_avg;
  int         taps [16];
  int         last_phase;
  logic [7:0] hang_cnt;

  ssb_result_t pending_results [$];

  function automatic int trunc16(int v);
    return int'(shortint'(v));
  endfunction

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  // First-octant angle, a <= b and b > 0.
  function automatic int octant_angle(int a, int b);
    return ((OCT_BASE - (OCT_SLOPE * a) / b) * a) / b;
  endfunction

  function automatic int carrier_phase(int q, int i);
    int r;
    if (iabs(q) > iabs(i))
      r = QUARTER - octant_angle(iabs(i), iabs(q));
    else
      r = (i == 0) ? 0 : octant_angle(iabs(q), iabs(i));
    if (i < 0)
      r = HALF_TURN - r;
    return trunc16((q < 0) ? -r : r);
  endfunction

  // Advances the modelled state by one microphone sample.
  function automatic ssb_result_t modulate_sample(logic signed [12:0] mic);
    int          x, ac, i_val, q_val, ai, aq, phase, dp, limit, k;
    logic [31:0] mag, level;
    ssb_result_t r;
    x = mic;
    for (k = 0; k < 15; k++)
      taps[k] = taps[k + 1];
    ac = trunc16(x * 2);
    ac = trunc16(ac + lowpass_mem);
    lowpass_mem = trunc16((x - 2 * lowpass_mem) / 3);
    dc_avg = trunc16((ac + 2 * dc_avg) / 3);
    taps[15] = trunc16(ac - dc_avg);

    i_val = trunc16(taps[7] * 2);
    q_val = trunc16(((taps[0] - taps[14]) * 2 + (taps[2] - taps[12]) * 8 +
                     (taps[4] - taps[10]) * 21 + (taps[6] - taps[8]) * 16) / 64 +
                    (taps[6] - taps[8]));

    ai = iabs(i_val / 2);
    aq = iabs(q_val / 2);
    mag = 32'((ai > aq) ? ai + aq / 4 : aq + ai / 4) & 32'hFFFF;

    if (mag > voice_threshold)
      hang_cnt = (hang_cnt != 0) ? HANG_NEXT : HANG_FIRST;
    else if (hang_cnt != 0)
      hang_cnt = hang_cnt - 8'd1;

    level = (mag << drive_shift) & 32'hFFFF;
    if (level > 32'd255 || drive_shift == DRIVE_FULL)
      level = 32'(LEVEL_MAX);
    if (hang_cnt == 0)
      level = '0;

    phase = carrier_phase(q_val, i_val);
    dp = trunc16(phase - last_phase);
    last_phase = phase;
    if (dp < 0)
      dp = trunc16(dp + UNIT_ANGLE);
    limit = (bandwidth_mode == BW_WIDE) ? UNIT_ANGLE :
            (bandwidth_mode == BW_NARROW) ? QUARTER : HALF_TURN;
    if (dp > limit) begin
      last_phase = trunc16(phase - (dp - limit));
      dp = limit;
    end

    r.freq_offset     = 13'(trunc16(dp * FREQ_SCALE));
    r.amplitude_level = level[7:0];
    r.transmit_active = (hang_cnt != 0);
    return r;
  endfunction

  always @(posedge clk) begin
    ssb_result_t want;
    if (!rst_n) begin
      drive_shift     <= 4'd2;
      voice_threshold <= 8'd4;
      bandwidth_mode  <= BW_WIDE;
      lowpass_mem = 0;
      dc_avg      = 0;
      last_phase  = 0;
      hang_cnt    = '0;
      foreach (taps[k])
        taps[k] = 0;
      pending_results.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DRIVE_SHIFT:     drive_shift     <= cfg_data[3:0];
          CFG_VOICE_THRESHOLD: voice_threshold <= cfg_data;
          CFG_BANDWIDTH_MODE:  bandwidth_mode  <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result freq %0d level %0d tx %0b", $time,
                   out_freq_offset, out_amplitude_level, out_transmit_active);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_freq_offset !== want.freq_offset ||
              out_amplitude_level !== want.amplitude_level ||
              out_transmit_active !== want.transmit_active) begin
            $display("%0t: expected freq %0d level %0d tx %0b, got freq %0d level %0d tx %0b",
                     $time, want.freq_offset, want.amplitude_level, want.transmit_active,
                     out_freq_offset, out_amplitude_level, out_transmit_active);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(modulate_sample(in_mic_sample));
      outstanding <= pending_results.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the SSB phase/amplitude modulator testbench: clock, reset, stimulus and verdict.
// Depends on ssbpam_pkg, the block itself and the ssbpam_checker module.
module tb_top;
  import ssbpam_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  // The longest honest quiet stretch is a settling pause plus register writes,
  // or a run of random stalls at 83 in a hundred; both stay far below this.
  localparam int WATCHDOG_LIMIT = 4000;
  // Pause after the last expected result has arrived, before a register write
  // or the verdict.
  localparam int SETTLE_CYCLES  = 32;
  localparam int PHASE_ITEMS    = 180;
  // Long enough for the hang counter to run down from 255 to zero.
  localparam int QUIET_ITEMS    = 280;

  // Bandwidth settings that share the half-turn phase-step limit.
  localparam logic [1:0] BW_HALF_1 = 2'd1;
  localparam logic [1:0] BW_HALF_2 = 2'd2;

  typedef enum logic [1:0] {
    BURST_TONE,
    BURST_NOISE,
    BURST_SOFT,
    BURST_QUIET
  } burst_kind_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [12:0] in_mic_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [12:0]        out_freq_offset;
  logic [7:0]         out_amplitude_level;
  logic               out_transmit_active;
  logic               cfg_we = 1'b0;
  cfg_index_t         cfg_index = CFG_DRIVE_SHIFT;
  logic [7:0]         cfg_data = '0;

  int mismatches;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Waveform generator state, kept across bursts and phases.
  burst_kind_t burst_kind = BURST_QUIET;
  int          burst_left = 0;
  int          tone_pos = 0;
  int          tone_dir = 1;
  int          tone_step = 1;
  int          tone_amp = 1;

  // Opening samples: silence (I and Q both zero), full-scale steps of either
  // sign, a Nyquist-rate square wave into the notch, and tiny values around
  // zero so that the phase swings through every quadrant.
  logic signed [12:0] edge_samples [$] = '{
    13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd4095, -13'sd4096, 13'sd4095, -13'sd4096,
    13'sd4095, 13'sd4095, 13'sd4095, 13'sd4095, -13'sd4096, -13'sd4096, 13'sd1,
    -13'sd1, 13'sd0, 13'sd2730, -13'sd2731, 13'sd0
  };

  always #4 clk = ~clk;

  ssb_phase_amplitude_modulator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mic_sample       (in_mic_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_freq_offset     (out_freq_offset),
    .out_amplitude_level (out_amplitude_level),
    .out_transmit_active (out_transmit_active),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  ssbpam_checker result_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mic_sample       (in_mic_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_freq_offset     (out_freq_offset),
    .out_amplitude_level (out_amplitude_level),
    .out_transmit_active (out_transmit_active),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  // The receiver stalls at random according to the current phase; with a
  // stall rate of zero it is always ready.
  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || (int'($urandom_range(99)) >= stall_pct);
  end

  // Watchdog: the count restarts on every accepted transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one sample and returns at the edge that accepts it. Valid is only
  // lowered when an idle gap is taken, so it never falls and rises in the same
  // time step, and it stays high with a stable payload until accepted.
  task automatic send_sample(input logic signed [12:0] sample);
    if (int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (int'($urandom_range(99)) < idle_pct)
        @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mic_sample <= sample;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  // Stops sending and waits until every expected result has arrived, then
  // lets the pipeline run empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are only ever rewritten with the block idle.
  task automatic set_mode(input logic [3:0] drive, input logic [7:0] threshold,
                          input logic [1:0] bandwidth, input int idle, input int stall);
    settle();
    write_reg(CFG_DRIVE_SHIFT, {4'd0, drive});
    write_reg(CFG_VOICE_THRESHOLD, threshold);
    write_reg(CFG_BANDWIDTH_MODE, {6'd0, bandwidth});
    idle_pct  = idle;
    stall_pct <= stall;
  endtask

  // Sends a run of samples made of bursts: half are triangle tones of random
  // pitch and level, which give the Hilbert stage well-formed signal and
  // steady phase steps, with white noise, near-threshold chatter and silence
  // mixed in to exercise the voice trigger and its hang time.
  task automatic run_phase(input int n_items);
    int                 k;
    int                 pick;
    logic signed [12:0] sample;
    for (k = 0; k < n_items; k++) begin
      if (burst_left == 0) begin
        burst_left = 8 + $urandom_range(56);
        pick = $urandom_range(19);
        if (pick < 10) begin
          burst_kind = BURST_TONE;
          tone_amp   = 1 + ($urandom_range(4094) >> $urandom_range(9));
          tone_step  = 1 + $urandom_range(tone_amp / 3);
          tone_pos   = 0;
          tone_dir   = 1;
        end else if (pick < 14) begin
          burst_kind = BURST_NOISE;
        end else if (pick < 17) begin
          burst_kind = BURST_SOFT;
        end else begin
          burst_kind = BURST_QUIET;
        end
      end
      burst_left--;
      case (burst_kind)
        BURST_TONE: begin
          tone_pos += tone_dir * tone_step;
          if (tone_pos > tone_amp) begin
            tone_pos = tone_amp;
            tone_dir = -1;
          end else if (tone_pos < -tone_amp) begin
            tone_pos = -tone_amp;
            tone_dir = 1;
          end
          sample = 13'(tone_pos);
        end
        BURST_NOISE: sample = 13'($urandom);
        BURST_SOFT:  sample = 13'(int'($urandom_range(30)) - 15);
        default:     sample = '0;
      endcase
      send_sample(sample);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening with the reset settings and no idling.
    foreach (edge_samples[k])
      send_sample(edge_samples[k]);

    // Reset settings, no idling on either side.
    run_phase(PHASE_ITEMS);

    // Full drive forced, every non-zero magnitude triggers, narrowest
    // bandwidth; the sender is mostly idle.
    set_mode(DRIVE_FULL, 8'd0, BW_NARROW, 83, 0);
    run_phase(PHASE_ITEMS);

    // Largest shift, where the shifted magnitude wraps, and the highest
    // threshold; the receiver stalls most of the time.
    set_mode(4'd15, 8'd255, BW_HALF_1, 0, 83);
    run_phase(PHASE_ITEMS);

    // No shift. A long silence first lets the hang counter expire, so the
    // next trigger loads it afresh; light idling on both sides.
    set_mode(4'd0, 8'd16, BW_HALF_2, 13, 13);
    burst_kind = BURST_QUIET;
    burst_left = QUIET_ITEMS;
    run_phase(QUIET_ITEMS + PHASE_ITEMS);

    // Shift just above full drive, lowest non-zero threshold, widest band.
    set_mode(4'd9, 8'd1, BW_WIDE, 0, 0);
    run_phase(PHASE_ITEMS);

    // A mid-range wrapping shift with a moderate threshold, sender idling.
    set_mode(4'd12, 8'd100, BW_HALF_1, 83, 0);
    run_phase(PHASE_ITEMS);

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
